>>> src/hpf_pkg.sv
// Shared types, constants and arithmetic helpers for the high-pass and pre-emphasis filter.
// Used by hpf_cfg, hpf_core and highpass_preemphasis_filter_top; depends on nothing else.
package hpf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int OUT_W     = 18;
	localparam int COEF_W    = 32;
	localparam int ACC_W     = 48;
	localparam int WIDE_W    = 56;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLE_ONE = 3'd0,
		REG_POLE_TWO = 3'd1,
		REG_ZERO_ONE = 3'd2,
		REG_ZERO_TWO = 3'd3,
		REG_EMPHASIS = 3'd4
	} cfg_reg_t;

	localparam logic signed [COEF_W-1:0] POLE_ONE_RST = -32'sd535794486;
	localparam logic signed [COEF_W-1:0] POLE_TWO_RST = 32'sd267361714;
	localparam logic signed [COEF_W-1:0] ZERO_ONE_RST = -32'sd536870912;
	localparam logic signed [COEF_W-1:0] ZERO_TWO_RST = 32'sd268435456;
	localparam logic signed [COEF_W-1:0] EMPHASIS_RST = 32'sd228170138;

	localparam logic signed [33:0] OUT_MAX = 34'sd131071;
	localparam logic signed [33:0] OUT_MIN = -34'sd131072;

	typedef struct packed {
		logic signed [COEF_W-1:0] pole_one;
		logic signed [COEF_W-1:0] pole_two;
		logic signed [COEF_W-1:0] zero_one;
		logic signed [COEF_W-1:0] zero_two;
		logic signed [COEF_W-1:0] emphasis;
	} coef_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] sample;
		logic                    frame_end;
		logic                    clipped;
	} result_t;

	function automatic logic signed [WIDE_W-1:0] ext56(input logic signed [ACC_W-1:0] v);
		return $signed({{(WIDE_W-ACC_W){v[ACC_W-1]}}, v});
	endfunction

	// Clamp to 48-bit signed: in range exactly when the bits above bit 47 match the sign.
	function automatic logic signed [ACC_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[WIDE_W-1:ACC_W-1];
		all_zero = ~|v[WIDE_W-1:ACC_W-1];
		if (all_one || all_zero)
			return v[ACC_W-1:0];
		else if (v[WIDE_W-1])
			return $signed({1'b1, {(ACC_W-1){1'b0}}});
		else
			return $signed({1'b0, {(ACC_W-1){1'b1}}});
	endfunction

	// Q3.28 coefficient times Q32.16 value, rounded half up back to Q32.16 and saturated.
	// The value is split into a signed upper half and an unsigned lower half so that
	// each partial product stays within 32 by 25 bits.
	function automatic logic signed [ACC_W-1:0] mulq(input logic signed [COEF_W-1:0] c,
			input logic signed [ACC_W-1:0] v);
		logic signed [23:0] hi;
		logic signed [24:0] lo;
		logic signed [55:0] p_hi;
		logic signed [56:0] p_lo;
		logic signed [81:0] acc;
		hi   = v[47:24];
		lo   = $signed({1'b0, v[23:0]});
		p_hi = c * hi;
		p_lo = c * lo;
		acc  = $signed({{2{p_hi[55]}}, p_hi, 24'd0})
			+ $signed({{25{p_lo[56]}}, p_lo})
			+ 82'sd134217728;
		return sat48($signed({{3{acc[80]}}, acc[80:28]}));
	endfunction

endpackage

>>> src/hpf_cfg.sv
// Coefficient register file of the filter, written through the configuration channel.
// Depends on hpf_pkg for the register codes, reset values and the coefficient struct.
module hpf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hpf_pkg::COEF_W-1:0]      cfg_data,
	output hpf_pkg::coef_t                  coef
);

	hpf_pkg::coef_t coef_q;

	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.pole_one <= hpf_pkg::POLE_ONE_RST;
			coef_q.pole_two <= hpf_pkg::POLE_TWO_RST;
			coef_q.zero_one <= hpf_pkg::ZERO_ONE_RST;
			coef_q.zero_two <= hpf_pkg::ZERO_TWO_RST;
			coef_q.emphasis <= hpf_pkg::EMPHASIS_RST;
		end else if (cfg_valid) begin
			// Indexes past the last register are dropped.
			unique case (cfg_index)
				hpf_pkg::REG_POLE_ONE: coef_q.pole_one <= $signed(cfg_data);
				hpf_pkg::REG_POLE_TWO: coef_q.pole_two <= $signed(cfg_data);
				hpf_pkg::REG_ZERO_ONE: coef_q.zero_one <= $signed(cfg_data);
				hpf_pkg::REG_ZERO_TWO: coef_q.zero_two <= $signed(cfg_data);
				hpf_pkg::REG_EMPHASIS: coef_q.emphasis <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

endmodule

>>> src/hpf_core.sv
// Filter datapath: biquad high-pass state, pre-emphasis state and output rounding.
// Depends on hpf_pkg for the multiply, saturation helpers and the result struct.
module hpf_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic signed [hpf_pkg::SAMPLE_W-1:0] sample,
	input  logic                                frame_end,
	input  hpf_pkg::coef_t                      coef,
	output hpf_pkg::result_t                    res
);

	logic signed [hpf_pkg::ACC_W-1:0] d1_q, d2_q, e_q;
	logic signed [hpf_pkg::ACC_W-1:0] xq, h;
	logic signed [hpf_pkg::ACC_W-1:0] m_b1, m_a1, m_b2, m_a2, m_e;
	logic signed [hpf_pkg::ACC_W-1:0] d1_n, d2_n, e_n;
	logic signed [49:0]               y_rnd;
	logic signed [33:0]               r;

	always_comb begin
		xq   = $signed({sample, 16'd0});
		h    = hpf_pkg::sat48(hpf_pkg::ext56(xq) + hpf_pkg::ext56(d1_q));
		m_b1 = hpf_pkg::mulq(coef.zero_one, xq);
		m_a1 = hpf_pkg::mulq(coef.pole_one, h);
		m_b2 = hpf_pkg::mulq(coef.zero_two, xq);
		m_a2 = hpf_pkg::mulq(coef.pole_two, h);
		m_e  = hpf_pkg::mulq(coef.emphasis, h);
		d1_n = hpf_pkg::sat48(hpf_pkg::ext56(d2_q) + hpf_pkg::ext56(m_b1)
			- hpf_pkg::ext56(m_a1));
		d2_n = hpf_pkg::sat48(hpf_pkg::ext56(m_b2) - hpf_pkg::ext56(m_a2));
		e_n  = hpf_pkg::sat48(-hpf_pkg::ext56(m_e));

		// The emphasis sum is not saturated; it is rounded half up to PCM units.
		y_rnd = $signed({{2{h[47]}}, h}) + $signed({{2{e_q[47]}}, e_q}) + 50'sd32768;
		r     = y_rnd[49:16];

		res.frame_end = frame_end;
		if (r > hpf_pkg::OUT_MAX) begin
			res.sample  = hpf_pkg::OUT_MAX[hpf_pkg::OUT_W-1:0];
			res.clipped = 1'b1;
		end else if (r < hpf_pkg::OUT_MIN) begin
			res.sample  = hpf_pkg::OUT_MIN[hpf_pkg::OUT_W-1:0];
			res.clipped = 1'b1;
		end else begin
			res.sample  = r[hpf_pkg::OUT_W-1:0];
			res.clipped = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
			e_q  <= '0;
		end else if (advance) begin
			d1_q <= d1_n;
			d2_q <= d2_n;
			e_q  <= e_n;
		end
	end

endmodule

>>> src/highpass_preemphasis_filter_top.sv
// Top level of the DC-blocking high-pass and pre-emphasis filter.
// Instantiates hpf_cfg and hpf_core; uses hpf_pkg.
//
// Channel   Direction  Transfer when          Content
// s_axis    in         tvalid && tready      tdata[15:0] sample_in, tlast frame_end_in
// m_axis    out        tvalid && tready      tdata[17:0] sample_out, tlast frame_end_out,
//                                             tuser clipped
// cfg       in         cfg_valid && cfg_ready cfg_index register number, cfg_data value
//
// One sample per cycle is sustained while the output is not stalled.
// The sample sits in the input register; the whole filter update is combinational
// from there into the output register, paced by the high-pass feedback multiplies.
// Reset clears the filter state and loads the default coefficients.
// When the output is stalled, the input register holds one more sample, then
// s_axis_tready drops.
module highpass_preemphasis_filter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,   // [15:0] sample_in
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,   // [17:0] sample_out, zero fill
	output logic                              m_axis_tlast,
	output logic                              m_axis_tuser,   // [0] clipped
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hpf_pkg::COEF_W-1:0]        cfg_data
);

	logic                                valid_s1;
	logic signed [hpf_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                last_s1;
	logic                                valid_s2;
	hpf_pkg::result_t                    res_s2;
	hpf_pkg::result_t                    res;
	hpf_pkg::coef_t                      coef;
	logic                                advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	hpf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	hpf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.sample    (sample_s1),
		.frame_end (last_s1),
		.coef      (coef),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= $signed(s_axis_tdata);
			last_s1   <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, res_s2.sample};
	assign m_axis_tlast  = res_s2.frame_end;
	assign m_axis_tuser  = res_s2.clipped;

endmodule

>>> verif/highpass_preemphasis_filter_top_test.sv
// Self-checking testbench for highpass_preemphasis_filter_top: streams PCM samples under
// random handshake idling, predicts each filtered sample and compares every output transfer.
// Depends on hpf_pkg and highpass_preemphasis_filter_top only.
module highpass_preemphasis_filter_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY        = 2;
	localparam int IDLE_PCT       = 36;
	localparam int STALL_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic signed [95:0] Q48_HI  = 96'sh7FFF_FFFF_FFFF;
	localparam logic signed [95:0] Q48_LO  = -96'sh8000_0000_0000;
	localparam logic signed [95:0] CLIP_HI = 96'sd131071;
	localparam logic signed [95:0] CLIP_LO = -96'sd131072;

	typedef struct {
		logic signed [hpf_pkg::OUT_W-1:0] sample;
		logic                             frame_end;
		logic                             clipped;
	} filt_out_t;

	logic                          clk;
	logic                          arst_n        = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [15:0]                   s_axis_tdata  = '0;   // [15:0] sample_in
	logic                          s_axis_tlast  = 1'b0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [23:0]                   m_axis_tdata;         // [17:0] sample_out, [23:18] zero fill
	logic                          m_axis_tlast;
	logic                          m_axis_tuser;         // [0] clipped
	logic                          cfg_valid     = 1'b0;
	logic                          cfg_ready;
	logic [hpf_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
	logic [hpf_pkg::COEF_W-1:0]    cfg_data      = '0;

	// Shadow of the coefficient registers and the filter state.
	logic signed [hpf_pkg::COEF_W-1:0] a1_coef   = hpf_pkg::POLE_ONE_RST;
	logic signed [hpf_pkg::COEF_W-1:0] a2_coef   = hpf_pkg::POLE_TWO_RST;
	logic signed [hpf_pkg::COEF_W-1:0] b1_coef   = hpf_pkg::ZERO_ONE_RST;
	logic signed [hpf_pkg::COEF_W-1:0] b2_coef   = hpf_pkg::ZERO_TWO_RST;
	logic signed [hpf_pkg::COEF_W-1:0] emph_coef = hpf_pkg::EMPHASIS_RST;
	logic signed [hpf_pkg::ACC_W-1:0]  delay_one  = '0;
	logic signed [hpf_pkg::ACC_W-1:0]  delay_two  = '0;
	logic signed [hpf_pkg::ACC_W-1:0]  emph_delay = '0;

	filt_out_t pending_out[$];
	int        errors        = 0;
	bit        steady        = 1'b0;
	int        stall_request = 0;

	highpass_preemphasis_filter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [hpf_pkg::ACC_W-1:0] clamp48(input logic signed [95:0] v);
		if (v > Q48_HI)
			return Q48_HI[hpf_pkg::ACC_W-1:0];
		else if (v < Q48_LO)
			return Q48_LO[hpf_pkg::ACC_W-1:0];
		return v[hpf_pkg::ACC_W-1:0];
	endfunction

	// Exact product, then round half up from Q28 fraction bits back to Q32.16.
	function automatic logic signed [hpf_pkg::ACC_W-1:0] scale_q28(
			input logic signed [hpf_pkg::COEF_W-1:0] c,
			input logic signed [hpf_pkg::ACC_W-1:0] v);
		logic signed [95:0] prod;
		prod = c * v;
		prod = prod + 96'sd134217728;
		return clamp48(prod >>> 28);
	endfunction

	function automatic filt_out_t filter_predict(input logic [15:0] smp, input logic fe);
		logic signed [95:0]               xq;
		logic signed [95:0]               acc;
		logic signed [95:0]               rnd;
		logic signed [hpf_pkg::ACC_W-1:0] h;
		logic signed [hpf_pkg::ACC_W-1:0] next_one;
		logic signed [hpf_pkg::ACC_W-1:0] next_two;
		filt_out_t                        res;
		xq = {{64{smp[15]}}, smp, 16'h0000};
		h = clamp48(xq + delay_one);
		acc = delay_two + scale_q28(b1_coef, xq[hpf_pkg::ACC_W-1:0]) - scale_q28(a1_coef, h);
		next_one = clamp48(acc);
		acc = scale_q28(b2_coef, xq[hpf_pkg::ACC_W-1:0]) - scale_q28(a2_coef, h);
		next_two = clamp48(acc);
		acc = h + emph_delay;
		rnd = (acc + 96'sd32768) >>> 16;
		acc = -scale_q28(emph_coef, h);
		emph_delay = clamp48(acc);
		delay_one = next_one;
		delay_two = next_two;
		res.frame_end = fe;
		res.clipped = 1'b0;
		if (rnd > CLIP_HI) begin
			rnd = CLIP_HI;
			res.clipped = 1'b1;
		end else if (rnd < CLIP_LO) begin
			rnd = CLIP_LO;
			res.clipped = 1'b1;
		end
		res.sample = rnd[hpf_pkg::OUT_W-1:0];
		return res;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			1, 2: return 16'(int'($urandom_range(128)) - 64);
			3: return 16'(int'($urandom_range(4096)) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly small moves around the default, sometimes anything, sometimes a rail.
	function automatic logic [hpf_pkg::COEF_W-1:0] pick_coef(
			input logic signed [hpf_pkg::COEF_W-1:0] dflt);
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'(int'(dflt) + int'($urandom_range(1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic send_sample(input logic [15:0] smp, input logic fe);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tlast  <= fe;
		do @(posedge clk); while (!s_axis_tready);
		pending_out.push_back(filter_predict(smp, fe));
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_sample(pick_sample(), $urandom_range(7) == 0);
	endtask

	// Stop offering samples and wait until every predicted result has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [hpf_pkg::CFG_IDX_W-1:0] idx,
			input logic [hpf_pkg::COEF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			hpf_pkg::REG_POLE_ONE: a1_coef   = val;
			hpf_pkg::REG_POLE_TWO: a2_coef   = val;
			hpf_pkg::REG_ZERO_ONE: b1_coef   = val;
			hpf_pkg::REG_ZERO_TWO: b2_coef   = val;
			hpf_pkg::REG_EMPHASIS: emph_coef = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_coefs(input logic [hpf_pkg::COEF_W-1:0] a1,
			input logic [hpf_pkg::COEF_W-1:0] a2,
			input logic [hpf_pkg::COEF_W-1:0] b1, input logic [hpf_pkg::COEF_W-1:0] b2,
			input logic [hpf_pkg::COEF_W-1:0] em);
		write_reg(hpf_pkg::REG_POLE_ONE, a1);
		write_reg(hpf_pkg::REG_POLE_TWO, a2);
		write_reg(hpf_pkg::REG_ZERO_ONE, b1);
		write_reg(hpf_pkg::REG_ZERO_TWO, b2);
		write_reg(hpf_pkg::REG_EMPHASIS, em);
	endtask

	task automatic write_defaults();
		write_coefs(hpf_pkg::POLE_ONE_RST, hpf_pkg::POLE_TWO_RST, hpf_pkg::ZERO_ONE_RST,
			hpf_pkg::ZERO_TWO_RST, hpf_pkg::EMPHASIS_RST);
	endtask

	// Rails, zero, sign steps and a DC run with the coefficients left at reset.
	task automatic test_directed_defaults();
		send_sample(16'h0000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0001, 1'b0);
		for (int i = 0; i < 10; i++)
			send_sample(i[0] ? 16'h8000 : 16'h7FFF, i == 9);
		for (int i = 0; i < 6; i++)
			send_sample(16'h7FFF, 1'b0);
		send_sample(16'h0000, 1'b1);
		wait_drained();
	endtask

	// Every register pinned to each rail, to zero, and the emphasis alone at both rails.
	task automatic test_coef_extremes();
		write_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_random(24);
		wait_drained();
		write_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_random(24);
		wait_drained();
		write_coefs('0, '0, '0, '0, '0);
		send_random(24);
		wait_drained();
		write_coefs(hpf_pkg::POLE_ONE_RST, hpf_pkg::POLE_TWO_RST, hpf_pkg::ZERO_ONE_RST,
			hpf_pkg::ZERO_TWO_RST, 32'h8000_0000);
		send_random(24);
		wait_drained();
		write_reg(hpf_pkg::REG_EMPHASIS, 32'h7FFF_FFFF);
		send_random(24);
		wait_drained();
	endtask

	// Writes to indexes past the last register must leave the coefficients alone.
	task automatic test_unknown_index();
		write_defaults();
		for (int i = hpf_pkg::REG_EMPHASIS + 1; i < (1 << hpf_pkg::CFG_IDX_W); i++)
			write_reg(hpf_pkg::CFG_IDX_W'(i), $urandom);
		send_random(24);
		wait_drained();
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 6; p++) begin
			if (p == 0)
				write_defaults();
			else
				write_coefs(pick_coef(hpf_pkg::POLE_ONE_RST), pick_coef(hpf_pkg::POLE_TWO_RST),
					pick_coef(hpf_pkg::ZERO_ONE_RST), pick_coef(hpf_pkg::ZERO_TWO_RST),
					pick_coef(hpf_pkg::EMPHASIS_RST));
			steady = (p == 3);
			// Frames of random length, each closed by a sample with the end mark.
			for (int f = 0; f < 8; f++) begin
				int len;
				len = $urandom_range(24, 8);
				for (int i = 0; i < len; i++)
					send_sample(pick_sample(), i == len - 1);
			end
			wait_drained();
			steady = 1'b0;
		end
	endtask

	// The receiver holds off while samples keep coming, so the input side must stall.
	task automatic test_backpressure();
		write_defaults();
		steady = 1'b1;
		stall_request = STALL_CYCLES;
		send_random(60);
		steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_pause_resume();
		send_random(40);
		wait_drained();
		send_random(40);
		wait_drained();
	endtask

	// Receiver: random ready, or a long hold-off when the test asks for one.
	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (stall_request != 0) begin
				n = stall_request;
				stall_request = 0;
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : check_results
		filt_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_out.size() == 0) begin
				flag_error($sformatf("output transfer with nothing expected, tdata=%h",
					m_axis_tdata));
			end else begin
				want = pending_out.pop_front();
				if (m_axis_tdata[hpf_pkg::OUT_W-1:0] !== want.sample)
					flag_error($sformatf("sample_out %0d, expected %0d",
						$signed(m_axis_tdata[hpf_pkg::OUT_W-1:0]), want.sample));
				if (m_axis_tdata[23:hpf_pkg::OUT_W] !== '0)
					flag_error($sformatf("tdata fill bits %b not zero",
						m_axis_tdata[23:hpf_pkg::OUT_W]));
				if (m_axis_tlast !== want.frame_end)
					flag_error($sformatf("frame end %b, expected %b", m_axis_tlast,
						want.frame_end));
				if (m_axis_tuser !== want.clipped)
					flag_error($sformatf("clipped %b, expected %b", m_axis_tuser, want.clipped));
			end
		end
	end

	// Ends the run when no transfer of any kind happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : main
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_coef_extremes();
		test_unknown_index();
		test_random_phases();
		test_backpressure();
		test_pause_resume();
		wait_drained();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
